FILE: hw/rtl/sorted_range_table_lookup_defines.svh
// Assertion macros for the sorted range table lookup checker.
// Depends on nothing; included by files that hold assertions.
`ifndef SORTED_RANGE_TABLE_LOOKUP_DEFINES_SVH
`define SORTED_RANGE_TABLE_LOOKUP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define SRTL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("srtl check failed");

// Consequent must hold in the cycle after the antecedent
`define SRTL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("srtl check failed");

`endif

FILE: hw/rtl/srtl_pkg.sv
// Package for the sorted range table lookup: field widths and codes.
// Used by the top level and the checker; depends on nothing.
`timescale 1ns / 1ps

package srtl_pkg;

  // Fixed payload widths
  localparam int unsigned OP_W     = 2;
  localparam int unsigned KEY_W    = 64;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned INDEX_W  = 10;
  localparam int unsigned COUNT_W  = 11;

  // Operation codes; code three is unused and leaves the table unchanged
  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_CLEAR  = 2'd2
  } op_e;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_ABSENT    = 2'd1,
    ST_RANGE_ERR = 2'd2
  } status_e;

  // Sequencer states
  typedef enum logic {
    S_IDLE   = 1'b0,
    S_SEARCH = 1'b1
  } state_e;

endpackage

FILE: hw/rtl/srtl_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module srtl_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/sorted_range_table_lookup.sv
// Sorted range table lookup: start key table in RAM, binary search sequencer.
// Depends on srtl_pkg and srtl_ram.
`timescale 1ns / 1ps

// Usage
//   Commands: operation_i and key_i are taken at a clock edge with start high
//   and busy low. Append stores a start key at the end of the table, lookup
//   searches for the last start key at most the query, clear empties it.
//   Config: expected_entries_i is written when cfg_we_i is high; write it
//   only while the block is idle.
//   Results: one beat per command, shown for exactly one cycle with done_o
//   high. The receiver cannot stall; a beat not taken is gone.
//   Timing: append, clear, the unused code and a lookup on an empty table
//   give their beat in the cycle after the command. A lookup over n entries
//   runs one RAM read and compare per search step, and its beat follows the
//   last step, with busy high meanwhile.
//   The rate is set by the single RAM read port feeding the one key compare.
//   A new command may be given while the previous beat is on the outputs.
//   Reset: the table is empty, the order flag is set and the expected count
//   is zero. RAM contents are not cleared; only written entries are read.

module sorted_range_table_lookup #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned KEY_BITS    = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Command channel
  input  logic                               start,
  output logic                               busy,
  input  logic [srtl_pkg::OP_W-1:0]          operation_i,
  input  logic [srtl_pkg::KEY_W-1:0]         key_i,
  // Configuration
  input  logic                               cfg_we_i,
  input  logic [srtl_pkg::COUNT_W-1:0]       expected_entries_i,
  // Result channel
  output logic                               done_o,
  output logic [srtl_pkg::STATUS_W-1:0]      status_o,
  output logic [srtl_pkg::INDEX_W-1:0]       entry_index_o,
  output logic                               table_valid_o,
  output logic [srtl_pkg::COUNT_W-1:0]       entries_held_o
);

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  srtl_pkg::state_e  state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              ord_q, ord_d;
  logic [KEY_BITS-1:0] last_q, last_d;
  logic [KEY_BITS-1:0] query_q, query_d;
  logic [CNT_W-1:0]  lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [srtl_pkg::COUNT_W-1:0] exp_q;
  logic              done_q, done_d;
  srtl_pkg::status_e status_q, status_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic              valid_q, valid_d;
  logic [CNT_W-1:0]  held_q;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr, ram_raddr;
  logic [KEY_BITS-1:0] ram_rdata, key_in;
  logic              accept, below;
  logic [CNT_W-1:0]  lo_n, hi_n, mid_n, half;

  assign accept = start && (state_q == srtl_pkg::S_IDLE);
  assign key_in = key_i[KEY_BITS-1:0];

  // Start key table
  srtl_ram #(
    .WIDTH (KEY_BITS),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (key_in),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // One search step: compare the read key, narrow the window, next midpoint
  assign below = query_q < ram_rdata;
  assign lo_n  = below ? lo_q : mid_q + CNT_W'(1);
  assign hi_n  = below ? mid_q : hi_q;
  assign mid_n = lo_n + ((hi_n - lo_n) >> 1);
  assign half  = cnt_q >> 1;

  // Sequencer: next state, table update and result beat
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    ord_d     = ord_q;
    last_d    = last_q;
    query_d   = query_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    mid_d     = mid_q;
    done_d    = 1'b0;
    status_d  = srtl_pkg::ST_OK;
    idx_d     = '0;
    ram_we    = 1'b0;
    ram_waddr = cnt_q[IDX_W-1:0];
    ram_raddr = half[IDX_W-1:0];
    case (state_q)
      srtl_pkg::S_IDLE: begin
        if (accept) begin
          done_d = 1'b1;
          case (srtl_pkg::op_e'(operation_i))
            srtl_pkg::OP_APPEND: begin
              if (cnt_q == CNT_W'(TABLE_DEPTH)) begin
                status_d = srtl_pkg::ST_RANGE_ERR;
              end else begin
                ram_we = 1'b1;
                if ((cnt_q != '0) && !(last_q < key_in)) begin
                  ord_d = 1'b0;
                end
                last_d = key_in;
                cnt_d  = cnt_q + CNT_W'(1);
              end
            end
            srtl_pkg::OP_LOOKUP: begin
              if (cnt_q == '0) begin
                status_d = srtl_pkg::ST_ABSENT;
              end else begin
                // first read is issued now at the midpoint of the whole table
                done_d  = 1'b0;
                query_d = key_in;
                lo_d    = '0;
                hi_d    = cnt_q;
                mid_d   = half;
                state_d = srtl_pkg::S_SEARCH;
              end
            end
            srtl_pkg::OP_CLEAR: begin
              cnt_d = '0;
              ord_d = 1'b1;
            end
            default: begin
              // unused code: no change, status ok
            end
          endcase
        end
      end
      srtl_pkg::S_SEARCH: begin
        lo_d      = lo_n;
        hi_d      = hi_n;
        mid_d     = mid_n;
        ram_raddr = mid_n[IDX_W-1:0];
        if (!(lo_n < hi_n)) begin
          done_d  = 1'b1;
          idx_d   = (lo_n == '0) ? '0 : lo_n - CNT_W'(1);
          state_d = srtl_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = srtl_pkg::S_IDLE;
      end
    endcase
  end

  // Table validity after this command
  always_comb begin
    valid_d = (cnt_d != '0) && ord_d &&
              ((exp_q == '0) || (32'(cnt_d) == 32'(exp_q)));
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= srtl_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      ord_q  <= 1'b1;
      exp_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      ord_q  <= ord_d;
      done_q <= done_d;
      if (cfg_we_i) begin
        exp_q <= expected_entries_i;
      end
    end
  end

  // Search window and result payload
  always_ff @(posedge clk_i) begin
    last_q  <= last_d;
    query_q <= query_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    mid_q   <= mid_d;
    if (done_d) begin
      status_q <= status_d;
      idx_q    <= idx_d;
      valid_q  <= valid_d;
      held_q   <= cnt_d;
    end
  end

  assign busy           = (state_q != srtl_pkg::S_IDLE);
  assign done_o         = done_q;
  assign status_o       = status_q;
  assign entry_index_o  = srtl_pkg::INDEX_W'(idx_q);
  assign table_valid_o  = valid_q;
  assign entries_held_o = srtl_pkg::COUNT_W'(held_q);

endmodule

FILE: hw/rtl/srtl_checker.sv
// Port-level checker for the sorted range table lookup, with its bind.
// Depends on srtl_pkg and sorted_range_table_lookup_defines.svh.
`timescale 1ns / 1ps
`include "sorted_range_table_lookup_defines.svh"

module srtl_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start,
  input logic                          busy,
  input logic [srtl_pkg::OP_W-1:0]     operation_i,
  input logic                          done_o,
  input logic [srtl_pkg::STATUS_W-1:0] status_o,
  input logic [srtl_pkg::INDEX_W-1:0]  entry_index_o,
  input logic                          table_valid_o,
  input logic [srtl_pkg::COUNT_W-1:0]  entries_held_o
);

  // A command other than lookup gives its beat in the next cycle
  `SRTL_ASSERT_NEXT(a_short_cmd_beat, start && !busy && (operation_i != srtl_pkg::OP_LOOKUP), done_o)

  // Clear leaves an empty table that does not read as valid
  `SRTL_ASSERT_NEXT(a_clear_empties, start && !busy && (operation_i == srtl_pkg::OP_CLEAR), (entries_held_o == '0) && !table_valid_o)

  // A valid table is never empty
  `SRTL_ASSERT_NOW(a_valid_nonempty, done_o && table_valid_o, entries_held_o != '0)

  // Absent only on an empty table, with index zero
  `SRTL_ASSERT_NOW(a_absent_empty, done_o && (status_o == srtl_pkg::ST_ABSENT), (entries_held_o == '0) && (entry_index_o == '0))

endmodule

bind sorted_range_table_lookup srtl_checker u_srtl_checker (.*);
